// ===== hw/rtl/dad_pkg.sv =====
// Package for the detection anchor decoder.
// Holds shared constants and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package dad_pkg;

   localparam int MAX_CLASSES = 128;
   localparam int MAX_ANCHORS = 16384;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HAS_OBJECTNESS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLASS_COUNT    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONF_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAD_LEFT       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAD_TOP        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_RATIO    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT   = 3'd7;

   localparam int QUOT_BITS = 15;

   typedef struct packed {
      logic       accept;
      logic       mul;
      logic       conf;
      logic       load;
      logic       step;
      logic       store;
      logic       wh;
      logic       fin;
      logic [1:0] corner_sel;
      logic [3:0] bit_idx;
   } dad_cmd_type;

   typedef struct packed {
      logic item_end;
      logic emit;
   } dad_status_type;

endpackage

// ===== hw/rtl/dad_ctrl.sv =====
// Controller state machine of the detection anchor decoder.
// Sequences the confidence check and the four corner divisions; uses dad_pkg.
`timescale 1ns / 1ps

module dad_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  dad_pkg::dad_status_type status,
   output dad_pkg::dad_cmd_type    cmd
);
   import dad_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_CONF  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_STORE = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [3:0] bit_ff, bit_in;
   logic       wh_ff, wh_in;
   logic       fin_ff, fin_in;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      bit_in = bit_ff;
      wh_in = 1'b0;
      fin_in = 1'b0;
      cmd = '0;
      cmd.corner_sel = sel_ff;
      cmd.bit_idx = bit_ff;
      cmd.wh = wh_ff;
      cmd.fin = fin_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = fin_ff;
            if (!fin_ff) begin
               cmd.accept = req_valid;
               if (req_valid && status.item_end) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_CONF;
         end
         ST_CONF: begin
            cmd.conf = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            sel_in = 2'd0;
            if (status.emit) begin
               state_in = ST_LOAD;
            end else begin
               fin_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            bit_in = 4'(QUOT_BITS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (bit_ff == 4'd0) begin
               state_in = ST_STORE;
            end else begin
               bit_in = bit_ff - 4'd1;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (sel_ff == 2'd3) begin
               wh_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               sel_in = sel_ff + 2'd1;
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            rsp_valid = !wh_ff;
            if (!wh_ff && !rsp_stall) begin
               fin_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff <= 2'd0;
         bit_ff <= 4'd0;
         wh_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         bit_ff <= bit_in;
         wh_ff <= wh_in;
         fin_ff <= fin_in;
      end
   end

endmodule

// ===== hw/rtl/dad_datapath.sv =====
// Datapath of the detection anchor decoder.
// Holds configuration, anchor state, the multiplier, the shared corner divider and
// the result registers; uses dad_pkg.
`timescale 1ns / 1ps

module dad_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [dad_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dad_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  logic signed [31:0]                   req_feature_value,
   input  logic                                 req_last_of_anchor,
   input  logic                                 req_last_of_frame,
   input  dad_pkg::dad_cmd_type                 cmd,
   output dad_pkg::dad_status_type              status,
   output logic [13:0]                          rsp_anchor_index,
   output logic [6:0]                           rsp_class_index,
   output logic signed [31:0]                   rsp_confidence,
   output logic [13:0]                          rsp_box_left,
   output logic [13:0]                          rsp_box_top,
   output logic [13:0]                          rsp_box_width,
   output logic [13:0]                          rsp_box_height
);
   import dad_pkg::*;

   logic        has_obj_ff;
   logic [7:0]  class_count_ff;
   logic [16:0] thr_ff;
   logic [9:0]  pad_left_ff, pad_top_ff;
   logic [23:0] ratio_ff;
   logic [13:0] img_w_ff, img_h_ff;

   logic [7:0]         pos_ff;
   logic signed [31:0] cx_ff, cy_ff, w_ff, h_ff, obj_ff, best_ff;
   logic [6:0]         best_class_ff;
   logic [13:0]        anchor_ff;
   logic               last_frame_ff;

   logic signed [63:0] prod_ff;
   logic signed [31:0] conf_ff;
   logic [35:0]        rem_ff;
   logic [QUOT_BITS-1:0] quot_ff;
   logic               neg_ff, over_ff;
   logic [13:0]        left_ff, top_ff, right_ff, bottom_ff;

   logic [13:0] out_anchor_ff, out_left_ff, out_top_ff, out_w_ff, out_h_ff;
   logic [6:0]  out_class_ff;
   logic signed [31:0] out_conf_ff;

   logic [7:0] offset, ncls, class_rel;
   logic       is_class;
   logic signed [63:0] round_sum;
   logic               no_sat;
   logic signed [31:0] conf_in;
   logic [23:0] ratio_eff;
   logic signed [31:0] center, size;
   logic [9:0]  pad;
   logic [13:0] limit;
   logic signed [36:0] numer;
   logic [39:0] over_lim, sub_val, rem_ext;
   logic [14:0] quot_lim;
   logic [13:0] corner_val;

   assign offset = has_obj_ff ? 8'd5 : 8'd4;
   assign ncls = (class_count_ff > 8'(MAX_CLASSES)) ? 8'(MAX_CLASSES) : class_count_ff;
   assign class_rel = pos_ff - offset;
   assign is_class = (pos_ff >= offset) && (class_rel < ncls);

   assign status.item_end = req_last_of_anchor || req_last_of_frame;
   assign status.emit = $signed({conf_ff[31], conf_ff}) > $signed({16'd0, thr_ff});

   assign round_sum = prod_ff + 64'sd32768;
   assign no_sat = (round_sum[63:47] == {17{1'b0}}) || (round_sum[63:47] == {17{1'b1}});
   assign conf_in = no_sat ? round_sum[47:16] :
                    (round_sum[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

   assign ratio_eff = (ratio_ff == 24'd0) ? 24'd1 : ratio_ff;
   assign center = cmd.corner_sel[0] ? cy_ff : cx_ff;
   assign size = cmd.corner_sel[0] ? h_ff : w_ff;
   assign pad = cmd.corner_sel[0] ? pad_top_ff : pad_left_ff;
   assign limit = cmd.corner_sel[0] ? img_h_ff : img_w_ff;

   always_comb begin
      numer = {{4{center[31]}}, center, 1'b0};
      if (cmd.corner_sel[1]) begin
         numer = numer + 37'(size);
      end else begin
         numer = numer - 37'(size);
      end
      numer = numer - $signed({10'd0, pad, 17'd0}) + $signed({13'd0, ratio_eff});
   end

   assign over_lim = {ratio_eff, 16'd0};
   assign rem_ext = {4'd0, rem_ff};
   assign sub_val = {15'd0, ratio_eff, 1'b0} << cmd.bit_idx;
   assign quot_lim = (quot_ff > {1'b0, limit}) ? {1'b0, limit} : quot_ff;
   assign corner_val = neg_ff ? 14'd0 : (over_ff ? limit : quot_lim[13:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         has_obj_ff <= 1'b0;
         class_count_ff <= 8'd80;
         thr_ff <= 17'd16384;
         pad_left_ff <= 10'd0;
         pad_top_ff <= 10'd0;
         ratio_ff <= 24'd65536;
         img_w_ff <= 14'd640;
         img_h_ff <= 14'd640;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HAS_OBJECTNESS: has_obj_ff <= csr_write_data[0];
            CSR_CLASS_COUNT:    class_count_ff <= csr_write_data[7:0];
            CSR_CONF_THRESHOLD: thr_ff <= csr_write_data[16:0];
            CSR_PAD_LEFT:       pad_left_ff <= csr_write_data[9:0];
            CSR_PAD_TOP:        pad_top_ff <= csr_write_data[9:0];
            CSR_SCALE_RATIO:    ratio_ff <= csr_write_data[23:0];
            CSR_IMAGE_WIDTH:    img_w_ff <= csr_write_data[13:0];
            CSR_IMAGE_HEIGHT:   img_h_ff <= csr_write_data[13:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.fin) begin
         pos_ff <= 8'd0;
         cx_ff <= '0;
         cy_ff <= '0;
         w_ff <= '0;
         h_ff <= '0;
         obj_ff <= 32'sd65536;
         best_ff <= -32'sd65536;
         best_class_ff <= 7'd0;
      end else if (cmd.accept) begin
         if (pos_ff == 8'd0) begin
            cx_ff <= req_feature_value;
         end else if (pos_ff == 8'd1) begin
            cy_ff <= req_feature_value;
         end else if (pos_ff == 8'd2) begin
            w_ff <= req_feature_value;
         end else if (pos_ff == 8'd3) begin
            h_ff <= req_feature_value;
         end else if (pos_ff == 8'd4 && has_obj_ff) begin
            obj_ff <= req_feature_value;
         end else if (is_class && req_feature_value > best_ff) begin
            best_ff <= req_feature_value;
            best_class_ff <= class_rel[6:0];
         end
         if (pos_ff != 8'hFF) begin
            pos_ff <= pos_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff <= 14'd0;
      end else if (cmd.fin) begin
         if (last_frame_ff) begin
            anchor_ff <= 14'd0;
         end else if (anchor_ff != 14'(MAX_ANCHORS - 1)) begin
            anchor_ff <= anchor_ff + 14'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_frame_ff <= req_last_of_frame;
      end
      if (cmd.mul) begin
         prod_ff <= obj_ff * best_ff;
      end
      if (cmd.conf) begin
         conf_ff <= conf_in;
      end
      if (cmd.load) begin
         rem_ff <= numer[35:0];
         quot_ff <= '0;
         neg_ff <= numer[36];
         over_ff <= !numer[36] && ({4'd0, numer[35:0]} >= over_lim);
      end
      if (cmd.step && rem_ext >= sub_val) begin
         rem_ff <= rem_ff - sub_val[35:0];
         quot_ff[cmd.bit_idx] <= 1'b1;
      end
      if (cmd.store) begin
         case (cmd.corner_sel)
            2'd0: left_ff <= corner_val;
            2'd1: top_ff <= corner_val;
            2'd2: right_ff <= corner_val;
            default: bottom_ff <= corner_val;
         endcase
      end
      if (cmd.wh) begin
         out_anchor_ff <= anchor_ff;
         out_class_ff <= best_class_ff;
         out_conf_ff <= conf_ff;
         out_left_ff <= left_ff;
         out_top_ff <= top_ff;
         out_w_ff <= (right_ff >= left_ff) ? right_ff - left_ff : 14'd0;
         out_h_ff <= (bottom_ff >= top_ff) ? bottom_ff - top_ff : 14'd0;
      end
   end

   assign rsp_anchor_index = out_anchor_ff;
   assign rsp_class_index = out_class_ff;
   assign rsp_confidence = out_conf_ff;
   assign rsp_box_left = out_left_ff;
   assign rsp_box_top = out_top_ff;
   assign rsp_box_width = out_w_ff;
   assign rsp_box_height = out_h_ff;

endmodule

// ===== hw/rtl/detection_anchor_decoder.sv =====
// Top level of the detection anchor decoder.
// Joins dad_ctrl and dad_datapath; uses dad_pkg.
//
// Usage: feature values of one anchor arrive on the req_ channel, one item per
// cycle while req_stall is low: cx, cy, w, h, an optional objectness value, then
// the class values. The item flagged last of anchor or last of frame closes the
// anchor. Plain features are taken without a stall. After the closing item the
// input stalls while the confidence is formed (multiply, confidence and check
// states). A box then takes 4 corners (load, 15 quotient bits, store) on one
// shared restoring divider. The result item is held on the rsp_ channel until
// the receiver lifts rsp_stall; the next anchor is taken once the anchor state
// is cleared on the return to idle. Configuration is written through csr_ while
// the block is idle; the user must keep to this, as the block does not enforce
// it. Synchronous reset loads the register defaults and clears the anchor state
// and anchor numbering; no result is pending after reset.
`timescale 1ns / 1ps

module detection_anchor_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [dad_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dad_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_feature_value,
   input  logic                                req_last_of_anchor,
   input  logic                                req_last_of_frame,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [13:0]                         rsp_anchor_index,
   output logic [6:0]                          rsp_class_index,
   output logic signed [31:0]                  rsp_confidence,
   output logic [13:0]                         rsp_box_left,
   output logic [13:0]                         rsp_box_top,
   output logic [13:0]                         rsp_box_width,
   output logic [13:0]                         rsp_box_height
);
   import dad_pkg::*;

   dad_cmd_type    cmd;
   dad_status_type status;

   dad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dad_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_feature_value  (req_feature_value),
      .req_last_of_anchor (req_last_of_anchor),
      .req_last_of_frame  (req_last_of_frame),
      .cmd                (cmd),
      .status             (status),
      .rsp_anchor_index   (rsp_anchor_index),
      .rsp_class_index    (rsp_class_index),
      .rsp_confidence     (rsp_confidence),
      .rsp_box_left       (rsp_box_left),
      .rsp_box_top        (rsp_box_top),
      .rsp_box_width      (rsp_box_width),
      .rsp_box_height     (rsp_box_height)
   );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for detection_anchor_decoder: directed and random anchors,
// checked field by field against an in-bench model of the decoder.
// Depends on dad_pkg and detection_anchor_decoder.
`timescale 1ns / 1ps

module tb_top;
   import dad_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [13:0]        anchor_index;
      logic [6:0]         class_index;
      logic signed [31:0] confidence;
      logic [13:0]        box_left;
      logic [13:0]        box_top;
      logic [13:0]        box_width;
      logic [13:0]        box_height;
   } box_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last_a;
      logic               last_f;
      logic               typed;
      box_type            known;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_HAS_OBJECTNESS;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_feature_value = '0;
   logic req_last_of_anchor = 1'b0;
   logic req_last_of_frame = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [13:0] rsp_anchor_index, rsp_box_left, rsp_box_top, rsp_box_width, rsp_box_height;
   logic [6:0] rsp_class_index;
   logic signed [31:0] rsp_confidence;

   detection_anchor_decoder u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Decoder model state and register copies.
   logic        m_has_obj;
   logic [7:0]  m_class_count;
   logic [16:0] m_threshold;
   logic [9:0]  m_pad_left, m_pad_top;
   logic [23:0] m_scale;
   logic [13:0] m_img_w, m_img_h;
   logic [7:0]  m_pos;
   logic signed [31:0] m_cx, m_cy, m_w, m_h, m_obj, m_best;
   logic [6:0]  m_best_class;
   logic [13:0] m_anchor;

   box_type boxes_due[$];
   int errors = 0, items_sent = 0, boxes_seen = 0, anchors_sent = 0;
   int idle_mode = 0, quiet_cycles = 0, hold_request = 0;

   function automatic longint floor_div(longint v, longint d);
      if (v >= 0) return v / d;
      return -((-(v + 1)) / d) - 1;
   endfunction

   function automatic longint corner_px(logic signed [31:0] center, logic signed [31:0] size,
                                        bit plus, logic [9:0] pad, logic [13:0] limit);
      longint r, n, q;
      r = (m_scale == 0) ? 1 : longint'(m_scale);
      n = 2 * longint'(center);
      n = plus ? n + longint'(size) : n - longint'(size);
      n -= longint'(pad) * 131072;
      q = floor_div(n + r, 2 * r);
      if (q < 0) q = 0;
      if (q > longint'(limit)) q = limit;
      return q;
   endfunction

   function automatic void clear_anchor_state();
      m_pos = 0;
      m_cx = 0;
      m_cy = 0;
      m_w = 0;
      m_h = 0;
      m_obj = 32'sd65536;
      m_best = -32'sd65536;
      m_best_class = 0;
   endfunction

   function automatic bit decode_feature(logic signed [31:0] v, logic la, logic lf,
                                         output box_type b);
      int offset, ncls;
      longint conf, l, t, r, bt, w, h;
      bit hit;
      offset = m_has_obj ? 5 : 4;
      ncls = (m_class_count < MAX_CLASSES) ? m_class_count : MAX_CLASSES;
      hit = 0;
      b = '0;
      if (m_pos == 0) m_cx = v;
      else if (m_pos == 1) m_cy = v;
      else if (m_pos == 2) m_w = v;
      else if (m_pos == 3) m_h = v;
      else if (m_pos == 4 && m_has_obj) m_obj = v;
      else if (m_pos >= offset && int'(m_pos) - offset < ncls && v > m_best) begin
         m_best = v;
         m_best_class = 7'(int'(m_pos) - offset);
      end
      if (m_pos < 255) m_pos++;
      if (la || lf) begin
         conf = floor_div(longint'(m_obj) * longint'(m_best) + 32768, 65536);
         if (conf > 64'sd2147483647) conf = 64'sd2147483647;
         if (conf < -64'sd2147483648) conf = -64'sd2147483648;
         if (conf > longint'(m_threshold)) begin
            l = corner_px(m_cx, m_w, 0, m_pad_left, m_img_w);
            t = corner_px(m_cy, m_h, 0, m_pad_top, m_img_h);
            r = corner_px(m_cx, m_w, 1, m_pad_left, m_img_w);
            bt = corner_px(m_cy, m_h, 1, m_pad_top, m_img_h);
            w = (r - l < 0) ? 0 : r - l;
            h = (bt - t < 0) ? 0 : bt - t;
            b.anchor_index = m_anchor;
            b.class_index = m_best_class;
            b.confidence = 32'(conf);
            b.box_left = 14'(l);
            b.box_top = 14'(t);
            b.box_width = 14'(w);
            b.box_height = 14'(h);
            hit = 1;
         end
         if (lf) m_anchor = 0;
         else if (m_anchor < MAX_ANCHORS - 1) m_anchor++;
         clear_anchor_state();
      end
      return hit;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input int unsigned val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val[CSR_DATA_WIDTH-1:0];
      @(posedge clock);
      case (idx)
         CSR_HAS_OBJECTNESS: m_has_obj = val[0];
         CSR_CLASS_COUNT:    m_class_count = val[7:0];
         CSR_CONF_THRESHOLD: m_threshold = val[16:0];
         CSR_PAD_LEFT:       m_pad_left = val[9:0];
         CSR_PAD_TOP:        m_pad_top = val[9:0];
         CSR_SCALE_RATIO:    m_scale = val[23:0];
         CSR_IMAGE_WIDTH:    m_img_w = val[13:0];
         default:            m_img_h = val[13:0];
      endcase
   endtask

   task automatic configure(input int unsigned obj, cc, thr, pl, pt, sr, iw, ih);
      write_reg(CSR_HAS_OBJECTNESS, obj);
      write_reg(CSR_CLASS_COUNT, cc);
      write_reg(CSR_CONF_THRESHOLD, thr);
      write_reg(CSR_PAD_LEFT, pl);
      write_reg(CSR_PAD_TOP, pt);
      write_reg(CSR_SCALE_RATIO, sr);
      write_reg(CSR_IMAGE_WIDTH, iw);
      write_reg(CSR_IMAGE_HEIGHT, ih);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (boxes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_feature(input logic signed [31:0] v, input logic la, lf,
                               input bit typed, input box_type known);
      box_type b;
      bit taken;
      while ((idle_mode == 0 && $urandom_range(99) < 38) ||
             (idle_mode == 1 && $urandom_range(99) < 74)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_feature_value <= v;
      req_last_of_anchor <= la;
      req_last_of_frame <= lf;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      items_sent++;
      if (la || lf) anchors_sent++;
      if (decode_feature(v, la, lf, b))
         boxes_due.insert(boxes_due.size(), typed ? known : b);
   endtask

   function automatic logic signed [31:0] random_feature(int pos);
      int offset;
      offset = m_has_obj ? 5 : 4;
      if ($urandom_range(9) == 0) return $urandom;
      if (pos < 2) return $urandom_range(0, 700 << 16);
      if (pos < 4) return $urandom_range(0, 300 << 16);
      if (pos == 4 && m_has_obj) return $urandom_range(0, 65536);
      return int'($urandom_range(0, 3 * 131072)) - 131072;
   endfunction

   task automatic random_anchor();
      int len, ncls;
      bit lf;
      ncls = (m_class_count < MAX_CLASSES) ? m_class_count : MAX_CLASSES;
      len = (m_has_obj ? 5 : 4) + ncls;
      if ($urandom_range(99) < 15) len = $urandom_range(1, len + 3);
      lf = ($urandom_range(99) < 8);
      for (int i = 0; i < len; i++)
         send_feature(random_feature(i), i == len - 1, lf && i == len - 1, 0, '0);
   endtask

   // Receiver: random stall, or a long hold-off when one is requested.
   int holds_served = 0, hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request != holds_served) begin
         holds_served = hold_request;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (idle_mode == 0) ? ($urandom_range(99) < 74) :
                      (idle_mode == 1) ? ($urandom_range(99) < 38) : 1'b0;
      end
   end

   always @(negedge clock) begin
      box_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            boxes_seen++;
            if (boxes_due.size() == 0) begin
               $error("unexpected result item, anchor_index %0d", rsp_anchor_index);
               errors++;
            end else begin
               e = boxes_due.pop_front();
               if (rsp_anchor_index !== e.anchor_index) begin
                  $error("anchor_index expected %0d actual %0d", e.anchor_index,
                         rsp_anchor_index);
                  errors++;
               end
               if (rsp_class_index !== e.class_index) begin
                  $error("class_index expected %0d actual %0d", e.class_index,
                         rsp_class_index);
                  errors++;
               end
               if (rsp_confidence !== e.confidence) begin
                  $error("confidence expected %0d actual %0d", e.confidence, rsp_confidence);
                  errors++;
               end
               if (rsp_box_left !== e.box_left) begin
                  $error("box_left expected %0d actual %0d", e.box_left, rsp_box_left);
                  errors++;
               end
               if (rsp_box_top !== e.box_top) begin
                  $error("box_top expected %0d actual %0d", e.box_top, rsp_box_top);
                  errors++;
               end
               if (rsp_box_width !== e.box_width) begin
                  $error("box_width expected %0d actual %0d", e.box_width, rsp_box_width);
                  errors++;
               end
               if (rsp_box_height !== e.box_height) begin
                  $error("box_height expected %0d actual %0d", e.box_height,
                         rsp_box_height);
                  errors++;
               end
            end
         end
      end
   end

   row_type directed[] = '{
      '{32'sd0, 0, 0, 0, '0},
      '{32'sd0, 0, 0, 0, '0},
      '{32'sd0, 0, 0, 0, '0},
      '{32'sd0, 0, 0, 0, '0},
      '{32'sd65536, 1, 0, 1, '{14'd0, 7'd0, 32'sd65536, 14'd0, 14'd0, 14'd0, 14'd0}},
      '{32'sd123, 1, 0, 0, '0},
      '{32'sh7fffffff, 0, 0, 0, '0},
      '{32'sh80000000, 0, 0, 0, '0},
      '{32'sh7fffffff, 0, 0, 0, '0},
      '{32'sh80000000, 0, 0, 0, '0},
      '{32'sh80000000, 0, 0, 0, '0},
      '{32'sh7fffffff, 0, 0, 0, '0},
      '{32'sh7fffffff, 0, 1, 0, '0},
      '{32'sd20971520, 0, 0, 0, '0},
      '{32'sd13107200, 0, 0, 0, '0},
      '{32'sd6553600, 0, 0, 0, '0},
      '{32'sd3276800, 0, 0, 0, '0},
      '{32'sd131072, 0, 0, 0, '0},
      '{32'sd131072, 1, 0, 0, '0},
      '{32'sd1000, 0, 0, 0, '0},
      '{-32'sd5, 0, 0, 0, '0},
      '{32'sd77, 0, 0, 0, '0},
      '{-32'sd9, 0, 0, 0, '0},
      '{-32'sd131072, 0, 0, 0, '0},
      '{-32'sd65536, 1, 1, 0, '0}
   };

   initial begin
      int budget;
      m_has_obj = 0;
      m_class_count = 80;
      m_threshold = 16384;
      m_pad_left = 0;
      m_pad_top = 0;
      m_scale = 65536;
      m_img_w = 640;
      m_img_h = 640;
      m_anchor = 0;
      clear_anchor_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_feature(directed[i].value, directed[i].last_a, directed[i].last_f,
                      directed[i].typed, directed[i].known);
      req_valid <= 1'b0;
      drain();

      for (int phase = 0; phase < 14; phase++) begin
         case (phase)
            0: configure(1, 3, 0, 640, 640, 1, 8192, 8192);
            1: configure(0, 1, 131071, 0, 0, 24'hffffff, 1, 1);
            2: configure(1, 0, 0, 3, 5, 0, 100, 50);
            3: configure(0, 200, 0, 0, 0, 65536, 640, 640);
            4: configure(1, 255, 65536, 10, 10, 65536, 640, 480);
            default: configure($urandom_range(1), $urandom_range(1, 8),
                               ($urandom_range(3) == 0) ? $urandom_range(65536) :
                               $urandom_range(2000),
                               $urandom_range(640), $urandom_range(640),
                               $urandom_range(16384, 131072),
                               $urandom_range(1, 8192), $urandom_range(1, 8192));
         endcase
         idle_mode = (items_sent < 500) ? 0 : (items_sent < 950) ? 1 : 2;
         if (phase == 5) hold_request++;
         budget = items_sent + ((phase == 3 || phase == 4) ? 250 : 60);
         while (items_sent < budget) random_anchor();
         req_valid <= 1'b0;
         drain();
      end

      $display("Sent %0d items in %0d anchors over 15 register settings; %0d boxes checked.",
               items_sent, anchors_sent, boxes_seen);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
